// ===== hw/rtl/nhm_pkg.sv =====
package nhm_pkg;

    // moving window of gyro samples
    localparam int WINDOW_SIZE = 64;
    localparam int PTR_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    // exact running sum of WINDOW_SIZE signed 32 bit rates
    localparam int SUM_W       = 32 + PTR_W;
    localparam int DIFF_W      = SUM_W + 1;

    // decoupling queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // stream and config widths
    localparam int IN_W       = 176;
    localparam int OUT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // sample kinds carried in tuser
    typedef enum logic [1:0] {
        K_IMU = 2'd0,
        K_INS = 2'd1,
        K_GPS = 2'd2,
        K_HDG = 2'd3
    } t_kind;

    // prioritized health codes
    typedef enum logic [2:0] {
        H_CM      = 3'd0,
        H_GYRO    = 3'd1,
        H_HEADING = 3'd2,
        H_SUBM    = 3'd3,
        H_POOR    = 3'd4
    } t_health;

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GYRO_THR = 3'd0,
        CFG_HDG_THR  = 3'd1,
        CFG_POS_LIM  = 3'd2,
        CFG_BASE_TOL = 3'd3,
        CFG_BASE_EXP = 3'd4,
        CFG_HACC_LIM = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] gyro_thr;
        logic [15:0] hdg_thr;
        logic [19:0] pos_lim;
        logic [15:0] base_tol;
        logic [15:0] base_exp;
        logic [16:0] hacc_lim;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        gyro_thr: 24'd13107,
        hdg_thr:  16'd768,
        pos_lim:  20'd1000,
        base_tol: 16'd30,
        base_exp: 16'd2020,
        hacc_lim: 17'd768
    };

    // one classified sample, gps and dual headings already folded into range
    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] mems;
        logic signed [31:0] fog;
        logic signed [17:0] heading;
        logic [19:0]        hacc;
        logic [16:0]        hdg_acc;
        logic [3:0]         fixq;
        logic [15:0]        baseline;
    } t_item;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

endpackage

// ===== hw/rtl/nhm_front.sv =====
module nhm_front (
    input  logic                     i_tvalid,
    output logic                     o_tready,
    input  logic [nhm_pkg::IN_W-1:0] i_tdata,
    input  logic [1:0]               i_tuser,
    input  nhm_pkg::t_q_status       i_qstat,
    output logic                     o_push,
    output nhm_pkg::t_item           o_item
);
    import nhm_pkg::*;

    // gps and dual headings above half a turn move down one full turn
    function automatic logic signed [17:0] fold_heading(input logic signed [17:0] h);
        logic signed [18:0] w;
        w = 19'(h);
        if (w > 19'sd46080) begin
            w = w - 19'sd92160;
        end
        return w[17:0];
    endfunction

    logic signed [17:0] ins_hdg;
    logic signed [17:0] gps_hdg;
    logic signed [17:0] dual_hdg;

    // accept whenever the queue has room
    assign o_tready = !i_qstat.full;
    assign o_push   = i_tvalid && !i_qstat.full;

    // unpack payload
    assign ins_hdg  = i_tdata[81:64];
    assign gps_hdg  = i_tdata[99:82];
    assign dual_hdg = i_tdata[158:141];

    always_comb begin
        o_item.kind     = t_kind'(i_tuser);
        o_item.mems     = i_tdata[31:0];
        o_item.fog      = i_tdata[63:32];
        o_item.hacc     = i_tdata[119:100];
        o_item.hdg_acc  = i_tdata[136:120];
        o_item.fixq     = i_tdata[140:137];
        o_item.baseline = i_tdata[174:159];
        // pick the heading that this kind updates
        case (t_kind'(i_tuser))
            K_INS:   o_item.heading = ins_hdg;
            K_GPS:   o_item.heading = fold_heading(gps_hdg);
            K_HDG:   o_item.heading = fold_heading(dual_hdg);
            default: o_item.heading = '0;
        endcase
    end

endmodule

// ===== hw/rtl/nhm_queue.sv =====
module nhm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  nhm_pkg::t_item     i_item,
    input  logic               i_pop,
    output nhm_pkg::t_item     o_item,
    output nhm_pkg::t_q_status o_stat
);
    import nhm_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_item       = r_mem[r_rd];
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/nhm_back.sv =====
module nhm_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  nhm_pkg::t_cfg             i_cfg,
    input  nhm_pkg::t_item            i_item,
    input  nhm_pkg::t_q_status        i_qstat,
    output logic                      o_pop,
    output logic                      o_tvalid,
    input  logic                      i_tready,
    output logic [nhm_pkg::OUT_W-1:0] o_tdata
);
    import nhm_pkg::*;

    // absolute heading difference folded across the 360 wrap
    function automatic logic signed [19:0] wrap_diff(input logic signed [18:0] d);
        logic signed [19:0] a;
        a = (d < 0) ? -20'(d) : 20'(d);
        if (a > 20'sd46080) begin
            a = 20'sd92160 - a;
        end
        return a;
    endfunction

    logic en;
    logic is_imu;
    logic is_ins;
    logic is_gps;
    logic is_hdg;

    // pipeline valids
    logic r_v1;
    logic r_v2;
    logic r_v3;

    // window state
    logic [PTR_W-1:0]       r_pos;
    logic [PTR_W-1:0]       n_pos;
    logic                   r_filled;
    logic                   n_filled;
    logic signed [SUM_W-1:0] r_mems_sum;
    logic signed [SUM_W-1:0] r_fog_sum;
    logic signed [SUM_W-1:0] n_mems_sum;
    logic signed [SUM_W-1:0] n_fog_sum;
    logic signed [31:0]     mems_mem [WINDOW_SIZE];
    logic signed [31:0]     fog_mem [WINDOW_SIZE];
    logic signed [31:0]     r_mems_rd;
    logic signed [31:0]     r_fog_rd;
    logic signed [31:0]     mems_old;
    logic signed [31:0]     fog_old;

    // latched sample state
    logic signed [17:0] r_fused;
    logic signed [17:0] r_single;
    logic signed [17:0] r_twin;
    logic [15:0]        r_base;
    logic [19:0]        r_hacc;
    logic [16:0]        r_hdg_acc;
    logic [3:0]         r_fixq;
    logic signed [17:0] n_fused;
    logic signed [17:0] n_single;
    logic signed [17:0] n_twin;
    logic [15:0]        n_base;
    logic [19:0]        n_hacc;
    logic [16:0]        n_hdg_acc;
    logic [3:0]         n_fixq;

    // stage 1 snapshot
    logic               r1_imu;
    logic signed [31:0] r1_mems;
    logic signed [31:0] r1_fog;
    logic               r1_old_ok;
    logic               r1_filled;
    logic signed [18:0] r1_dg;
    logic signed [18:0] r1_dd;
    logic signed [16:0] r1_berr;
    logic               r1_rtk;
    logic               r1_good;
    logic               r1_single_ok;
    logic signed [18:0] n_dg;
    logic signed [18:0] n_dd;
    logic signed [16:0] n_berr;

    // stage 2 snapshot
    logic signed [19:0] r2_dg;
    logic signed [19:0] r2_dd;
    logic               r2_base_ok;
    logic               r2_filled;
    logic               r2_rtk;
    logic               r2_good;
    logic               r2_single_ok;
    logic [16:0]        berr_abs;

    // result stage
    logic signed [19:0]       thr;
    logic signed [19:0]       thr_lo;
    logic signed [DIFF_W-1:0] sum_diff;
    logic signed [DIFF_W-1:0] gyro_lim;
    logic                     gyro;
    logic                     stable;
    t_health                  status;
    t_health                  r_status;
    logic                     r_rtk;
    logic                     r_gyro;
    logic                     r_stable;
    logic                     r_good;

    // the whole pipe moves when the output register is free or drained
    assign en     = !r_v3 || i_tready;
    assign o_pop  = en && !i_qstat.empty;
    assign is_imu = o_pop && (i_item.kind == K_IMU);
    assign is_ins = o_pop && (i_item.kind == K_INS);
    assign is_gps = o_pop && (i_item.kind == K_GPS);
    assign is_hdg = o_pop && (i_item.kind == K_HDG);

    // stage 1 next state
    always_comb begin
        n_pos    = r_pos;
        n_filled = r_filled;
        if (is_imu) begin
            if (r_pos == PTR_W'(WINDOW_SIZE - 1)) begin
                n_pos    = '0;
                n_filled = 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
        n_fused   = is_ins ? i_item.heading : r_fused;
        n_single  = is_gps ? i_item.heading : r_single;
        n_hacc    = is_gps ? i_item.hacc : r_hacc;
        n_hdg_acc = is_gps ? i_item.hdg_acc : r_hdg_acc;
        n_fixq    = is_gps ? i_item.fixq : r_fixq;
        n_twin    = is_hdg ? i_item.heading : r_twin;
        n_base    = is_hdg ? i_item.baseline : r_base;
    end

    assign n_dg   = 19'(n_fused) - 19'(n_single);
    assign n_dd   = 19'(n_fused) - 19'(n_twin);
    assign n_berr = signed'({1'b0, n_base}) - signed'({1'b0, i_cfg.base_exp});

    // stage 2 running sums, a slot never written reads as zero
    assign mems_old   = r1_old_ok ? r_mems_rd : '0;
    assign fog_old    = r1_old_ok ? r_fog_rd : '0;
    assign n_mems_sum = r_mems_sum + SUM_W'(r1_mems) - SUM_W'(mems_old);
    assign n_fog_sum  = r_fog_sum + SUM_W'(r1_fog) - SUM_W'(fog_old);
    assign berr_abs   = (r1_berr < 0) ? 17'(-r1_berr) : 17'(r1_berr);

    // result stage: flags and priority
    assign thr      = signed'({4'b0, i_cfg.hdg_thr});
    assign thr_lo   = 20'sd46080 - thr;
    assign sum_diff = DIFF_W'(r_mems_sum) - DIFF_W'(r_fog_sum);
    assign gyro_lim = signed'(DIFF_W'(i_cfg.gyro_thr) * DIFF_W'(WINDOW_SIZE));
    assign gyro     = r2_filled && (sum_diff > gyro_lim);
    assign stable   = (!r2_single_ok || (thr > r2_dg) || (thr_lo < r2_dg))
                   && (!r2_base_ok || (thr > r2_dd));

    always_comb begin
        if (r2_rtk) begin
            status = H_CM;
        end else if (gyro) begin
            status = H_GYRO;
        end else if (!stable) begin
            status = H_HEADING;
        end else if (r2_good) begin
            status = H_SUBM;
        end else begin
            status = H_POOR;
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_pos      <= '0;
            r_filled   <= 1'b0;
            r_mems_sum <= '0;
            r_fog_sum  <= '0;
            r_fused    <= '0;
            r_single   <= '0;
            r_twin     <= '0;
            r_base     <= '0;
            r_hacc     <= '0;
            r_hdg_acc  <= '0;
            r_fixq     <= '0;
        end else if (en) begin
            r_v1      <= o_pop;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_pos     <= n_pos;
            r_filled  <= n_filled;
            r_fused   <= n_fused;
            r_single  <= n_single;
            r_twin    <= n_twin;
            r_base    <= n_base;
            r_hacc    <= n_hacc;
            r_hdg_acc <= n_hdg_acc;
            r_fixq    <= n_fixq;
            if (r_v1 && r1_imu) begin
                r_mems_sum <= n_mems_sum;
                r_fog_sum  <= n_fog_sum;
            end
        end
    end

    // gyro rings, old slot read before the new rate lands
    always_ff @(posedge i_clk) begin
        if (en && is_imu) begin
            r_mems_rd      <= mems_mem[r_pos];
            r_fog_rd       <= fog_mem[r_pos];
            mems_mem[r_pos] <= i_item.mems;
            fog_mem[r_pos]  <= i_item.fog;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_imu       <= is_imu;
            r1_mems      <= i_item.mems;
            r1_fog       <= i_item.fog;
            r1_old_ok    <= r_filled;
            r1_filled    <= n_filled;
            r1_dg        <= n_dg;
            r1_dd        <= n_dd;
            r1_berr      <= n_berr;
            r1_rtk       <= (n_fixq >= 4'd2);
            r1_good      <= (n_hacc < i_cfg.pos_lim);
            r1_single_ok <= (n_hdg_acc < i_cfg.hacc_lim);

            r2_dg        <= wrap_diff(r1_dg);
            r2_dd        <= wrap_diff(r1_dd);
            r2_base_ok   <= (berr_abs < {1'b0, i_cfg.base_tol});
            r2_filled    <= r1_filled;
            r2_rtk       <= r1_rtk;
            r2_good      <= r1_good;
            r2_single_ok <= r1_single_ok;

            r_status     <= status;
            r_rtk        <= r2_rtk;
            r_gyro       <= gyro;
            r_stable     <= stable;
            r_good       <= r2_good;
        end
    end

    assign o_tvalid = r_v3;
    assign o_tdata  = {1'b0, r_good, r_stable, r_gyro, r_rtk, r_status};

endmodule

// ===== hw/rtl/navigation_health_monitor.sv =====
// navigation health monitor
// s_axis carries one sensor sample per transaction, its kind in tuser
// (imu, ins, gps, dual antenna heading); m_axis returns one status
// transaction for every sample, in order: a 3 bit prioritized health code
// and the rtk fix, gyro mismatch, heading stable and position good flags.
// the cfg channel writes the six threshold registers (index 0 to 5) and is
// always ready; write it only while no sample is in flight.
// a sample is accepted into a 4 entry queue whenever the queue has room,
// and passes through the queue, ring access, running sum update and result
// register before m_axis. while m_axis keeps up, one sample per cycle is
// sustained: the gyro rings are read and written at the same slot in the
// same cycle and the running sums are updated one stage later.
// after reset all state, sums and rings read as zero and the registers hold
// their defaults; no sweep is needed, an unwritten ring slot reads as zero.
// when m_axis stalls the back pipeline holds, the queue absorbs up to four
// more samples and then s_axis_tready drops.
module navigation_health_monitor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // s_axis_tdata, low bit up: mems_rate 32, fog_rate 32, fused_hdg 18,
    // single_hdg 18, horiz_acc 20, single_hdg_acc 17, fix_quality 4,
    // dual_heading 18, dual_baseline 16, 1 pad bit
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [nhm_pkg::IN_W-1:0]       s_axis_tdata,
    // s_axis_tuser: cmd 2
    input  logic [1:0]                     s_axis_tuser,
    // m_axis_tdata, low bit up: status_code 3, rtk_fix 1,
    // gyro_mismatch 1, heading_stable 1, position_good 1, 1 pad bit
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [nhm_pkg::OUT_W-1:0]      m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nhm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nhm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nhm_pkg::*;

    t_cfg      r_cfg;
    t_item     f_item;
    t_item     q_item;
    t_q_status q_stat;
    logic      push;
    logic      pop;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GYRO_THR: r_cfg.gyro_thr <= i_cfg_data[23:0];
                CFG_HDG_THR:  r_cfg.hdg_thr  <= i_cfg_data[15:0];
                CFG_POS_LIM:  r_cfg.pos_lim  <= i_cfg_data[19:0];
                CFG_BASE_TOL: r_cfg.base_tol <= i_cfg_data[15:0];
                CFG_BASE_EXP: r_cfg.base_exp <= i_cfg_data[15:0];
                CFG_HACC_LIM: r_cfg.hacc_lim <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // front: accept and classify
    nhm_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_qstat  (q_stat),
        .o_push   (push),
        .o_item   (f_item)
    );

    // decoupling queue
    nhm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // back: state update and status
    nhm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (q_item),
        .i_qstat  (q_stat),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

    // queue never holds more than its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("queue occupancy beyond depth");

    // a pop always finds an entry
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // status priority agrees with the flags
    a_status_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[3] == (m_axis_tdata[2:0] == H_CM))
            && (m_axis_tdata[3] || !m_axis_tdata[4]
                || (m_axis_tdata[2:0] == H_GYRO))))
        else $error("health status disagrees with flags");

    // nothing leaves right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

// ===== tb/navigation_health_monitor_tb.sv =====
`timescale 1ns / 1ps

module navigation_health_monitor_tb;
    import nhm_pkg::*;

    localparam longint HALF_TURN = 46080;
    localparam longint FULL_TURN = 92160;
    localparam int PHASE_ITEMS = 90;

    // one sensor sample as it travels on s_axis
    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] mems;
        logic signed [31:0] fog;
        logic signed [17:0] ins_hdg;
        logic signed [17:0] gps_hdg;
        logic [19:0]        hacc;
        logic [16:0]        hdg_acc;
        logic [3:0]         fixq;
        logic signed [17:0] dual_hdg;
        logic [15:0]        baseline;
    } t_sample;

    // directed row: sample plus an optional hand-written status
    typedef struct packed {
        t_sample    smp;
        logic       typed;
        logic [7:0] want;
    } t_probe;

    typedef enum {R_OPEN, R_HALF, R_MOSTLY, R_SPARSE} t_drain_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = K_IMU;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_GYRO_THR;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // side info travelling with the offered transaction
    logic       offered_typed = 1'b0;
    logic [7:0] offered_want = '0;

    // predictor state
    t_cfg   limits = CFG_RESET;
    longint mems_win [WINDOW_SIZE];
    longint fog_win [WINDOW_SIZE];
    longint mems_acc, fog_acc;
    int     rate_slot;
    bit     win_full;
    longint fused, single_hdg, twin_hdg, twin_base, hacc_st, hdgacc_st;
    int     fixq_st;

    logic [7:0] pending_health [$];
    t_probe     probes [$];

    int  mismatch_count, samples_sent, results_checked, settings_used, in_stall_cycles;
    int  status_seen [8];
    int  burst_left;
    bit  hold_off_req;

    navigation_health_monitor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // fold headings above half a turn down by a full turn
    function automatic longint fold_heading(logic signed [17:0] h);
        longint v;
        v = longint'(h);
        if (v > HALF_TURN) v -= FULL_TURN;
        return v;
    endfunction

    // absolute heading gap with wrap, may go negative for odd inputs
    function automatic longint turn_gap(longint a, longint b);
        longint d;
        d = a - b;
        if (d < 0) d = -d;
        if (d > HALF_TURN) d = FULL_TURN - d;
        return d;
    endfunction

    // update the monitor state with one sample and derive its status
    function automatic logic [7:0] compute_health(t_sample s);
        longint thr, dg, dd, base_err, gyro_lim;
        bit rtk, gyro, stable, good, single_ok, base_ok;
        t_health code;
        case (s.kind)
            K_IMU: begin
                mems_acc += longint'(s.mems) - mems_win[rate_slot];
                fog_acc  += longint'(s.fog) - fog_win[rate_slot];
                mems_win[rate_slot] = longint'(s.mems);
                fog_win[rate_slot]  = longint'(s.fog);
                rate_slot++;
                if (rate_slot >= WINDOW_SIZE) begin
                    rate_slot = 0;
                    win_full = 1'b1;
                end
            end
            K_INS: fused = longint'(s.ins_hdg);
            K_GPS: begin
                single_hdg = fold_heading(s.gps_hdg);
                hacc_st    = longint'(s.hacc);
                hdgacc_st  = longint'(s.hdg_acc);
                fixq_st    = int'(s.fixq);
            end
            default: begin
                twin_hdg  = fold_heading(s.dual_hdg);
                twin_base = longint'(s.baseline);
            end
        endcase

        rtk      = fixq_st >= 2;
        gyro_lim = longint'(limits.gyro_thr) * WINDOW_SIZE;
        gyro     = win_full && ((mems_acc - fog_acc) > gyro_lim);

        // stable heading: valid sources agree with the fused heading, a gps gap near half a turn passes too
        thr       = longint'(limits.hdg_thr);
        dg        = turn_gap(fused, single_hdg);
        dd        = turn_gap(fused, twin_hdg);
        single_ok = hdgacc_st < longint'(limits.hacc_lim);
        base_err  = twin_base - longint'(limits.base_exp);
        if (base_err < 0) base_err = -base_err;
        base_ok   = base_err < longint'(limits.base_tol);
        stable    = 1'b1;
        if (single_ok) stable = (thr > dg) || ((HALF_TURN - thr) < dg);
        if (base_ok) stable = stable && (thr > dd);
        good = hacc_st < longint'(limits.pos_lim);

        if (rtk) code = H_CM;
        else if (gyro) code = H_GYRO;
        else if (!stable) code = H_HEADING;
        else if (good) code = H_SUBM;
        else code = H_POOR;
        return {1'b0, good, stable, gyro, rtk, code};
    endfunction

    function automatic int near(int c, int spread);
        return c + int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // heading offsets around agreement, the half-turn edge and the full turn, or spread over a full turn either way
    function automatic int heading_offset();
        int thr, off;
        thr = int'(limits.hdg_thr);
        case ($urandom_range(0, 3))
            0: off = near(0, thr + 4);
            1: off = near(int'(HALF_TURN), thr + 4);
            2: off = near(int'(FULL_TURN), thr + 4);
            default: off = int'($urandom_range(0, 184320)) - int'(FULL_TURN);
        endcase
        if ($urandom_range(0, 1)) off = -off;
        return off;
    endfunction

    // random sample, mostly steered near the decision edges
    function automatic t_sample draw_sample();
        t_sample s;
        int pick, base;
        pick = $urandom_range(0, 99);
        if (pick < 40) s.kind = K_IMU;
        else if (pick < 55) s.kind = K_INS;
        else if (pick < 80) s.kind = K_GPS;
        else s.kind = K_HDG;
        s.mems     = $urandom;
        s.fog      = $urandom;
        s.ins_hdg  = 18'($urandom);
        s.gps_hdg  = 18'($urandom);
        s.hacc     = 20'($urandom);
        s.hdg_acc  = 17'($urandom);
        s.fixq     = 4'($urandom);
        s.dual_hdg = 18'($urandom);
        s.baseline = 16'($urandom);
        if ($urandom_range(0, 19) != 0) begin
            case (s.kind)
                K_IMU: begin
                    base   = int'($urandom_range(0, 200000)) - 100000;
                    s.fog  = base;
                    s.mems = near(base + int'(limits.gyro_thr), 20);
                end
                K_INS: s.ins_hdg = 18'(int'($urandom_range(0, 184320)) - int'(FULL_TURN));
                K_GPS: begin
                    s.gps_hdg = 18'(fused + longint'(heading_offset()));
                    s.hacc    = 20'(near(int'(limits.pos_lim), 3));
                    s.hdg_acc = 17'(near(int'(limits.hacc_lim), 3));
                    if ($urandom_range(0, 3) != 0) s.fixq = 4'($urandom_range(0, 1));
                end
                default: begin
                    s.dual_hdg = 18'(fused + longint'(heading_offset()));
                    s.baseline = 16'(near(int'(limits.base_exp),
                                          int'(limits.base_tol) + 3));
                end
            endcase
        end
        return s;
    endfunction

    function automatic void add_probe(t_kind kind, logic [31:0] mems, logic [31:0] fog,
                                      logic [17:0] hdg, logic [19:0] hacc,
                                      logic [16:0] hdg_acc, logic [3:0] fixq,
                                      logic [15:0] baseline, logic typed, logic [7:0] want);
        t_probe p;
        p.smp          = '0;
        p.smp.kind     = kind;
        p.smp.mems     = mems;
        p.smp.fog      = fog;
        p.smp.ins_hdg  = hdg;
        p.smp.gps_hdg  = hdg;
        p.smp.dual_hdg = hdg;
        p.smp.hacc     = hacc;
        p.smp.hdg_acc  = hdg_acc;
        p.smp.fixq     = fixq;
        p.smp.baseline = baseline;
        p.typed        = typed;
        p.want         = want;
        probes.push_back(p);
    endfunction

    // offer one sample and wait for its transaction, then maybe idle a while
    task automatic send_sample(t_sample s, logic typed, logic [7:0] want, bit no_gaps);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= s.kind;
        s_axis_tdata  <= {1'b0, s.baseline, s.dual_hdg, s.fixq, s.hdg_acc, s.hacc,
                          s.gps_hdg, s.ins_hdg, s.fog, s.mems};
        offered_typed <= typed;
        offered_want  <= want;
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
        if (!no_gaps) begin
            if (burst_left == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(0, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // stop offering and let every expected status drain
    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        while (pending_health.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // write all six threshold registers, block is idle here
    task automatic write_thresholds(t_cfg c);
        t_cfg_idx idx;
        logic [CFG_DATA_W-1:0] val;
        idx = CFG_GYRO_THR;
        do begin
            case (idx)
                CFG_GYRO_THR: val = c.gyro_thr;
                CFG_HDG_THR:  val = CFG_DATA_W'(c.hdg_thr);
                CFG_POS_LIM:  val = CFG_DATA_W'(c.pos_lim);
                CFG_BASE_TOL: val = CFG_DATA_W'(c.base_tol);
                CFG_BASE_EXP: val = CFG_DATA_W'(c.base_exp);
                default:      val = CFG_DATA_W'(c.hacc_lim);
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            do @(posedge i_clk); while (!o_cfg_ready);
            idx = idx.next();
        end while (idx != CFG_GYRO_THR);
        i_cfg_valid <= 1'b0;
        limits = c;
        settings_used++;
    endtask

    function automatic void check_field(string name, logic [2:0] exp_v, logic [2:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // predict on every accepted sample transaction
    always @(posedge i_clk) begin
        t_sample s;
        logic [7:0] predicted;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            s.kind     = t_kind'(s_axis_tuser);
            s.mems     = s_axis_tdata[31:0];
            s.fog      = s_axis_tdata[63:32];
            s.ins_hdg  = s_axis_tdata[81:64];
            s.gps_hdg  = s_axis_tdata[99:82];
            s.hacc     = s_axis_tdata[119:100];
            s.hdg_acc  = s_axis_tdata[136:120];
            s.fixq     = s_axis_tdata[140:137];
            s.dual_hdg = s_axis_tdata[158:141];
            s.baseline = s_axis_tdata[174:159];
            predicted  = compute_health(s);
            pending_health.push_back(offered_typed ? offered_want : predicted);
        end
        if (i_rst_n && s_axis_tvalid && !s_axis_tready) in_stall_cycles++;
    end

    // compare every status transaction with the oldest expectation
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_health.size() == 0) begin
                $display("%0t: unexpected status, expected none, got %h", $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_health.pop_front();
                check_field("status_code", want[2:0], m_axis_tdata[2:0]);
                check_field("rtk_fix", {2'b0, want[3]}, {2'b0, m_axis_tdata[3]});
                check_field("gyro_mismatch", {2'b0, want[4]}, {2'b0, m_axis_tdata[4]});
                check_field("heading_stable", {2'b0, want[5]}, {2'b0, m_axis_tdata[5]});
                check_field("position_good", {2'b0, want[6]}, {2'b0, m_axis_tdata[6]});
                results_checked++;
                status_seen[m_axis_tdata[2:0]]++;
            end
        end
    end

    // result side: stretches of different drain patterns, long hold-off on request
    initial begin
        int seg_left, hold_left;
        t_drain_mode mode;
        seg_left  = 0;
        hold_left = 0;
        mode      = R_OPEN;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = 80;
            end
            if (seg_left == 0) begin
                mode     = t_drain_mode'($urandom_range(0, 3));
                seg_left = $urandom_range(4, 40);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    R_OPEN:   m_axis_tready <= 1'b1;
                    R_HALF:   m_axis_tready <= ($urandom_range(0, 1) != 0);
                    R_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default:  m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // main sequence
    initial begin
        t_cfg c;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: extremes, every kind, heading fold, baseline edges
        add_probe(K_IMU, 32'h0, 32'h0, 18'h0, 20'h0, 17'h0, 4'h0, 16'h0,
                  1'b1, {1'b0, 1'b1, 1'b1, 1'b0, 1'b0, H_SUBM});
        add_probe(K_IMU, 32'h7fffffff, 32'h80000000, 18'h0, 20'h0, 17'h0, 4'h0, 16'h0, 0, 0);
        add_probe(K_IMU, 32'h80000000, 32'h7fffffff, 18'h0, 20'h0, 17'h0, 4'h0, 16'h0, 0, 0);
        add_probe(K_INS, 32'h0, 32'h0, 18'h1ffff, 20'h0, 17'h0, 4'h0, 16'h0, 0, 0);
        add_probe(K_INS, 32'h0, 32'h0, 18'h20000, 20'h0, 17'h0, 4'h0, 16'h0, 0, 0);
        add_probe(K_INS, 32'h0, 32'h0, 18'd92160, 20'h0, 17'h0, 4'h0, 16'h0, 0, 0);
        add_probe(K_INS, 32'h0, 32'h0, -18'sd92160, 20'h0, 17'h0, 4'h0, 16'h0, 0, 0);
        add_probe(K_INS, 32'h0, 32'h0, 18'h0, 20'h0, 17'h0, 4'h0, 16'h0, 0, 0);
        add_probe(K_GPS, 32'h0, 32'h0, 18'h0, 20'h0, 17'h0, 4'h0, 16'h0,
                  1'b1, {1'b0, 1'b1, 1'b1, 1'b0, 1'b0, H_SUBM});
        add_probe(K_GPS, 32'h0, 32'h0, 18'd10000, 20'h0, 17'h0, 4'h0, 16'h0,
                  1'b1, {1'b0, 1'b1, 1'b0, 1'b0, 1'b0, H_HEADING});
        add_probe(K_GPS, 32'h0, 32'h0, 18'd46081, 20'h0, 17'h0, 4'h0, 16'h0, 0, 0);
        add_probe(K_GPS, 32'h0, 32'h0, 18'h1ffff, 20'h0, 17'h0, 4'h0, 16'h0, 0, 0);
        add_probe(K_GPS, 32'h0, 32'h0, 18'h20000, 20'h0, 17'h0, 4'h0, 16'h0, 0, 0);
        add_probe(K_GPS, 32'h0, 32'h0, 18'h0, 20'hfffff, 17'h1ffff, 4'hf, 16'h0,
                  1'b1, {1'b0, 1'b0, 1'b1, 1'b0, 1'b1, H_CM});
        add_probe(K_GPS, 32'h0, 32'h0, 18'h0, 20'd999, 17'd767, 4'd2, 16'h0,
                  1'b1, {1'b0, 1'b1, 1'b1, 1'b0, 1'b1, H_CM});
        add_probe(K_GPS, 32'h0, 32'h0, 18'h0, 20'd1000, 17'd768, 4'd1, 16'h0,
                  1'b1, {1'b0, 1'b0, 1'b1, 1'b0, 1'b0, H_POOR});
        add_probe(K_HDG, 32'h0, 32'h0, 18'h0, 20'h0, 17'h0, 4'h0, 16'd2020, 0, 0);
        add_probe(K_HDG, 32'h0, 32'h0, 18'd92160, 20'h0, 17'h0, 4'h0, 16'd2049, 0, 0);
        add_probe(K_HDG, 32'h0, 32'h0, 18'd1000, 20'h0, 17'h0, 4'h0, 16'd1991, 0, 0);
        add_probe(K_HDG, 32'h0, 32'h0, 18'h20000, 20'h0, 17'h0, 4'h0, 16'hffff, 0, 0);
        add_probe(K_HDG, 32'h0, 32'h0, 18'h1ffff, 20'h0, 17'h0, 4'h0, 16'd2050, 0, 0);
        add_probe(K_HDG, 32'h0, 32'h0, 18'h0, 20'h0, 17'h0, 4'h0, 16'h0, 0, 0);
        add_probe(K_INS, 32'hffffffff, 32'hffffffff, 18'd100, 20'hfffff, 17'h1ffff, 4'hf,
                  16'hffff, 0, 0);
        foreach (probes[i]) send_sample(probes[i].smp, probes[i].typed, probes[i].want, 1'b0);
        drain_all();

        // random phases, each under its own thresholds
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: c = '{gyro_thr: 24'hffffff, hdg_thr: 16'd46080, pos_lim: 20'hfffff,
                         base_tol: 16'hffff, base_exp: 16'hffff, hacc_lim: 17'd92160};
                1: c = '0;
                2: c = CFG_RESET;
                3: begin
                    c.gyro_thr = 24'($urandom_range(0, 65535));
                    c.hdg_thr  = 16'($urandom_range(0, 4096));
                    c.pos_lim  = 20'($urandom_range(0, 4000));
                    c.base_tol = 16'($urandom_range(0, 100));
                    c.base_exp = 16'($urandom_range(0, 65535));
                    c.hacc_lim = 17'($urandom_range(0, 4096));
                end
                default: begin
                    c.gyro_thr = 24'($urandom_range(0, 16777215));
                    c.hdg_thr  = 16'($urandom_range(0, 46080));
                    c.pos_lim  = 20'($urandom_range(0, 1048575));
                    c.base_tol = 16'($urandom_range(0, 65535));
                    c.base_exp = 16'($urandom_range(0, 65535));
                    c.hacc_lim = 17'($urandom_range(0, 92160));
                end
            endcase
            write_thresholds(c);
            // back-to-back samples against a long result stall
            if (ph == 2) hold_off_req = 1'b1;
            repeat (PHASE_ITEMS) send_sample(draw_sample(), 1'b0, 8'h0, ph == 2);
            drain_all();
        end

        $display("covered %0d samples over %0d threshold settings, %0d statuses checked",
                 samples_sent, settings_used + 1, results_checked);
        $display("statuses cm %0d gyro %0d heading %0d subm %0d poor %0d, input stall %0d cyc",
                 status_seen[H_CM], status_seen[H_GYRO], status_seen[H_HEADING],
                 status_seen[H_SUBM], status_seen[H_POOR], in_stall_cycles);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
